// ===== rtl/sbti_pkg.sv =====
// sbti_pkg: shared types and constants for the stack byte-code thread interpreter.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
package sbti_pkg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RDOUT,
        S_SCAN,
        S_DECODE,
        S_EXEC,
        S_IND,
        S_IND2
    } state_t;

    // host commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // thread instruction set (byte mod 24)
    localparam logic [4:0] OP_NOP  = 5'd0;
    localparam logic [4:0] OP_ORG  = 5'd1;
    localparam logic [4:0] OP_EQU  = 5'd2;
    localparam logic [4:0] OP_JMP  = 5'd3;
    localparam logic [4:0] OP_JMPZ = 5'd4;
    localparam logic [4:0] OP_PSHL = 5'd5;
    localparam logic [4:0] OP_PSH  = 5'd6;
    localparam logic [4:0] OP_PSHI = 5'd7;
    localparam logic [4:0] OP_POP  = 5'd8;
    localparam logic [4:0] OP_POPI = 5'd9;
    localparam logic [4:0] OP_ADD  = 5'd10;
    localparam logic [4:0] OP_SUB  = 5'd11;
    localparam logic [4:0] OP_INC  = 5'd12;
    localparam logic [4:0] OP_DEC  = 5'd13;
    localparam logic [4:0] OP_AND  = 5'd14;
    localparam logic [4:0] OP_OR   = 5'd15;
    localparam logic [4:0] OP_XOR  = 5'd16;
    localparam logic [4:0] OP_NOT  = 5'd17;
    localparam logic [4:0] OP_ROR  = 5'd18;
    localparam logic [4:0] OP_ROL  = 5'd19;
    localparam logic [4:0] OP_PIP  = 5'd20;
    localparam logic [4:0] OP_PDP  = 5'd21;
    localparam logic [4:0] OP_DUP  = 5'd22;
    localparam logic [4:0] OP_SAY  = 5'd23;

    // byte mod 24 via reciprocal 171/4096, exact for all 8-bit inputs
    function automatic logic [4:0] op_of(input logic [7:0] b);
        logic [15:0] p;
        logic [3:0]  q;
        logic [7:0]  r;
        p = 16'(b) * 16'd171;
        q = p[15:12];
        r = b - 8'(q) * 8'd24;
        return r[4:0];
    endfunction

endpackage

// ===== rtl/stack_bytecode_thread_interpreter_top.sv =====
// Stack byte-code thread interpreter: shared heap RAM, per-thread stack RAM, sequencer.
// Depends on sbti_pkg.
`timescale 1ns / 1ps
//
//  channel   signals                          direction  timing
//  command   start, busy, opcode/address/data in         taken when start & !busy
//  result    strobe, thread_index/value/last  out        one cycle per word, no stall
//  config    cfg_write, cfg_data              in         written on any edge with cfg_write
//
// Heap write: busy covers S_MOD, read: S_MOD then S_RDOUT; S_MOD first subtracts HEAP_BYTES from
// the address until it lies in the heap. The read word comes out in the same cycle that busy drops.
// Tick: an inactive thread is skipped in S_SCAN; an active thread runs S_SCAN, S_DECODE, S_EXEC and,
// for indirect ops, S_IND and S_IND2 (heap RAM port is serial: fetch, operand, up to two indirect reads).
// After reset the heap RAM is zeroed, one byte a cycle, with busy high.
// Results go out as they are made; the receiver cannot stall.
module stack_bytecode_thread_interpreter_top
    import sbti_pkg::*;
#(
    parameter int THREAD_COUNT = 8,
    parameter int HEAP_BYTES   = 2048,
    parameter int STACK_DEPTH  = 16
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [10:0] address,
    input  logic [7:0]  data,
    output logic        strobe,
    output logic [2:0]  thread_index,
    output logic [7:0]  value,
    output logic        last,
    input  logic        cfg_write,
    input  logic [7:0]  cfg_data
);

    localparam int AW   = $clog2(HEAP_BYTES);
    localparam int AXW  = (AW > 11) ? AW : 11;
    localparam int SD   = THREAD_COUNT * STACK_DEPTH;
    localparam int SAW  = $clog2(SD);
    localparam int FW   = $clog2(STACK_DEPTH + 1);
    localparam int TIW  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam logic [7:0] TMASK = 8'((1 << THREAD_COUNT) - 1);

    function automatic logic [AW-1:0] heap_addr(input logic [AW-1:0] b, input logic [7:0] r);
        logic [AW:0] s;
        s = {1'b0, b} + (AW+1)'(r);
        if (32'(s) >= HEAP_BYTES)
        begin
            s = s - (AW+1)'(HEAP_BYTES);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [SAW-1:0] stk_idx(input logic [TIW-1:0] t, input logic [FW-1:0] s);
        return SAW'(int'(t) * STACK_DEPTH + int'(s));
    endfunction

    // memories
    logic [7:0] heap_mem [HEAP_BYTES];
    logic [7:0] stk_mem  [SD];
    logic           hwe;
    logic [AW-1:0]  hwa, hra;
    logic [7:0]     hwd, hrd_reg;
    logic           swe;
    logic [SAW-1:0] swa, sra;
    logic [7:0]     swd, srd_reg;

    always_ff @(posedge clk)
    begin
        if (hwe)
        begin
            heap_mem[hwa] <= hwd;
        end
        hrd_reg <= heap_mem[hra];
    end

    always_ff @(posedge clk)
    begin
        if (swe)
        begin
            stk_mem[swa] <= swd;
        end
        srd_reg <= stk_mem[sra];
    end

    // per-thread context
    logic [7:0]    pc_reg   [THREAD_COUNT];
    logic [FW-1:0] fill_reg [THREAD_COUNT];
    logic [AW-1:0] base_reg [THREAD_COUNT];
    logic          upd;
    logic [7:0]    pc_new;
    logic [FW-1:0] fill_new;
    logic [AW-1:0] base_new;

    state_t         state_reg, state_next;
    logic [TIW-1:0] t_reg, t_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic [AXW-1:0] addr_reg, addr_next;
    logic [1:0]     cmd_reg, cmd_next;
    logic [7:0]     data_reg, data_next;
    logic [7:0]     instr_reg, instr_next;
    logic [7:0]     a_reg, a_next;
    logic [7:0]     opnd_reg, opnd_next;
    logic [7:0]     active_mask_reg;
    logic           strobe_reg, strobe_next;
    logic [2:0]     tidx_reg, tidx_next;
    logic [7:0]     value_reg, value_next;
    logic           last_reg, last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            t_reg           <= '0;
            clr_reg         <= '0;
            strobe_reg      <= 1'b0;
            active_mask_reg <= 8'd1;
            for (int i = 0; i < THREAD_COUNT; i++)
            begin
                pc_reg[i]   <= 8'd0;
                fill_reg[i] <= '0;
                base_reg[i] <= AW'((255 * i) % HEAP_BYTES);
            end
        end
        else
        begin
            state_reg  <= state_next;
            t_reg      <= t_next;
            clr_reg    <= clr_next;
            strobe_reg <= strobe_next;
            if (cfg_write)
            begin
                active_mask_reg <= cfg_data;
            end
            if (upd)
            begin
                pc_reg[t_reg]   <= pc_new;
                fill_reg[t_reg] <= fill_new;
                base_reg[t_reg] <= base_new;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        cmd_reg   <= cmd_next;
        data_reg  <= data_next;
        instr_reg <= instr_next;
        a_reg     <= a_next;
        opnd_reg  <= opnd_next;
        tidx_reg  <= tidx_next;
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    // current thread view
    logic [7:0]    pc;
    logic [FW-1:0] fill, nf;
    logic [AW-1:0] base;
    logic          has1, has2;
    logic [4:0]    op;
    logic [7:0]    mask_eff;
    logic [8:0]    later;
    logic          fin;
    logic [1:0]    pop_n;
    logic          push_en;
    logic [7:0]    push_val;

    always_comb
    begin
        pc       = pc_reg[t_reg];
        fill     = fill_reg[t_reg];
        base     = base_reg[t_reg];
        has1     = (fill != '0);
        has2     = (32'(fill) >= 2);
        op       = op_of(instr_reg);
        mask_eff = active_mask_reg & TMASK;
        later    = 9'(mask_eff) >> (4'(t_reg) + 4'd1);

        state_next  = state_reg;
        t_next      = t_reg;
        clr_next    = clr_reg;
        addr_next   = addr_reg;
        cmd_next    = cmd_reg;
        data_next   = data_reg;
        instr_next  = instr_reg;
        a_next      = a_reg;
        opnd_next   = opnd_reg;
        strobe_next = 1'b0;
        tidx_next   = tidx_reg;
        value_next  = value_reg;
        last_next   = last_reg;
        hwe = 1'b0;
        hwa = '0;
        hwd = 8'd0;
        hra = '0;
        sra = '0;
        swe = 1'b0;
        swa = '0;
        swd = 8'd0;
        upd      = 1'b0;
        pc_new   = pc + 8'd1;
        base_new = base;
        fill_new = fill;
        fin      = 1'b0;
        pop_n    = 2'd0;
        push_en  = 1'b0;
        push_val = 8'd0;
        nf       = fill;

        unique case (state_reg)
            S_CLEAR:
            begin
                hwe      = 1'b1;
                hwa      = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (32'(clr_reg) == HEAP_BYTES - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = opcode;
                    addr_next = AXW'(address);
                    data_next = data;
                    t_next    = '0;
                    unique case (opcode)
                        CMD_WRITE, CMD_READ: state_next = S_MOD;
                        CMD_TICK:            state_next = S_SCAN;
                        default:             state_next = S_IDLE;
                    endcase
                end
            end
            S_MOD:
            begin
                // reduce the host address into the heap one subtract a cycle
                if (32'(addr_reg) >= HEAP_BYTES)
                begin
                    addr_next = addr_reg - AXW'(HEAP_BYTES);
                end
                else if (cmd_reg == CMD_WRITE)
                begin
                    hwe        = 1'b1;
                    hwa        = AW'(addr_reg);
                    hwd        = data_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    hra        = AW'(addr_reg);
                    state_next = S_RDOUT;
                end
            end
            S_RDOUT:
            begin
                strobe_next = 1'b1;
                tidx_next   = 3'd0;
                value_next  = hrd_reg;
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_SCAN:
            begin
                if (mask_eff[3'(t_reg)])
                begin
                    hra        = heap_addr(base, pc);
                    sra        = stk_idx(t_reg, fill - FW'(1));
                    state_next = S_DECODE;
                end
                else if (32'(t_reg) == THREAD_COUNT - 1)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    t_next = t_reg + TIW'(1);
                end
            end
            S_DECODE:
            begin
                instr_next  = hrd_reg;
                a_next      = srd_reg;
                strobe_next = 1'b1;
                tidx_next   = 3'(t_reg);
                value_next  = hrd_reg;
                last_next   = (later == 9'd0);
                hra         = heap_addr(base, pc + 8'd1);
                sra         = stk_idx(t_reg, fill - FW'(2));
                state_next  = S_EXEC;
            end
            S_EXEC:
            begin
                // hrd_reg: operand byte, srd_reg: second stack entry
                opnd_next = hrd_reg;
                fin       = 1'b1;
                case (op)
                    OP_ORG:
                    begin
                        base_new = heap_addr(base, pc);
                        pc_new   = 8'd1;
                    end
                    OP_EQU, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR:
                    begin
                        if (has2)
                        begin
                            pop_n   = 2'd2;
                            push_en = 1'b1;
                            case (op)
                                OP_EQU:  push_val = {7'd0, a_reg == srd_reg};
                                OP_ADD:  push_val = a_reg + srd_reg;
                                OP_SUB:  push_val = a_reg - srd_reg;
                                OP_AND:  push_val = a_reg & srd_reg;
                                OP_OR:   push_val = a_reg | srd_reg;
                                default: push_val = a_reg ^ srd_reg;
                            endcase
                        end
                    end
                    OP_JMP:
                    begin
                        pc_new = hrd_reg;
                    end
                    OP_JMPZ:
                    begin
                        if (has1)
                        begin
                            pop_n = 2'd1;
                        end
                        pc_new = (has1 && a_reg == 8'd0) ? hrd_reg : pc + 8'd2;
                    end
                    OP_PSHL:
                    begin
                        push_en  = 1'b1;
                        push_val = hrd_reg;
                        pc_new   = pc + 8'd2;
                    end
                    OP_PSH, OP_PSHI, OP_PIP, OP_PDP:
                    begin
                        fin        = 1'b0;
                        hra        = heap_addr(base, hrd_reg);
                        state_next = S_IND;
                    end
                    OP_POP:
                    begin
                        if (has1)
                        begin
                            hwe    = 1'b1;
                            hwa    = heap_addr(base, hrd_reg);
                            hwd    = a_reg;
                            pop_n  = 2'd1;
                            pc_new = pc + 8'd2;
                        end
                    end
                    OP_POPI:
                    begin
                        if (has1)
                        begin
                            fin        = 1'b0;
                            hra        = heap_addr(base, hrd_reg);
                            state_next = S_IND;
                        end
                    end
                    OP_INC, OP_DEC, OP_NOT:
                    begin
                        if (has1)
                        begin
                            pop_n   = 2'd1;
                            push_en = 1'b1;
                            case (op)
                                OP_INC:  push_val = a_reg + 8'd1;
                                OP_DEC:  push_val = a_reg - 8'd1;
                                default: push_val = ~a_reg;
                            endcase
                        end
                    end
                    OP_ROR, OP_ROL:
                    begin
                        // needs two entries, pops one
                        if (has2)
                        begin
                            pop_n    = 2'd1;
                            push_en  = 1'b1;
                            push_val = (op == OP_ROR) ? (a_reg >> hrd_reg[2:0])
                                                      : (a_reg << hrd_reg[2:0]);
                            pc_new   = pc + 8'd2;
                        end
                    end
                    OP_DUP:
                    begin
                        if (has1)
                        begin
                            push_en  = 1'b1;
                            push_val = a_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_IND:
            begin
                fin    = 1'b1;
                pc_new = pc + 8'd2;
                case (op)
                    OP_PSH:
                    begin
                        push_en  = 1'b1;
                        push_val = hrd_reg;
                    end
                    OP_PSHI:
                    begin
                        fin        = 1'b0;
                        hra        = heap_addr(base, hrd_reg);
                        state_next = S_IND2;
                    end
                    OP_POPI:
                    begin
                        hwe   = 1'b1;
                        hwa   = heap_addr(base, hrd_reg);
                        hwd   = a_reg;
                        pop_n = 2'd1;
                    end
                    default:
                    begin
                        hwe = 1'b1;
                        hwa = heap_addr(base, opnd_reg);
                        hwd = (op == OP_PIP) ? hrd_reg + 8'd1 : hrd_reg - 8'd1;
                    end
                endcase
            end
            S_IND2:
            begin
                fin      = 1'b1;
                pc_new   = pc + 8'd2;
                push_en  = 1'b1;
                push_val = hrd_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // stack update: pops first, then the push, dropped when full
        nf = fill - FW'(pop_n);
        if (fin && push_en && 32'(nf) < STACK_DEPTH)
        begin
            swe = 1'b1;
            swa = stk_idx(t_reg, nf);
            swd = push_val;
            nf  = nf + FW'(1);
        end
        fill_new = nf;

        if (fin)
        begin
            upd = 1'b1;
            if (32'(t_reg) == THREAD_COUNT - 1)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                t_next     = t_reg + TIW'(1);
                state_next = S_SCAN;
            end
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = strobe_reg;
    assign thread_index = tidx_reg;
    assign value        = value_reg;
    assign last         = last_reg;

endmodule

// ===== bench/stack_bytecode_thread_interpreter_top_test.sv =====
// Self-checking bench for stack_bytecode_thread_interpreter_top: heap write/read, ticks.
// Carries its own model of the threads, heap and stacks. Depends on sbti_pkg.
`timescale 1ns / 1ps
module stack_bytecode_thread_interpreter_top_test
    import sbti_pkg::*;
();

    localparam int NTHR  = 8;
    localparam int HBYTES = 2048;
    localparam int SDEPTH = 16;

    // host command with no function
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0] thr;
        logic [7:0] val;
        logic       lst;
    } word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  opcode = CMD_WRITE;
    logic [10:0] address = '0;
    logic [7:0]  data = '0;
    logic        strobe;
    logic [2:0]  thread_index;
    logic [7:0]  value;
    logic        last;
    logic        cfg_write = 1'b0;
    logic [7:0]  cfg_data = '0;

    stack_bytecode_thread_interpreter_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .address(address), .data(data),
        .strobe(strobe), .thread_index(thread_index), .value(value), .last(last),
        .cfg_write(cfg_write), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // model state
    logic [7:0]  mem [HBYTES];
    logic [7:0]  stk [NTHR][SDEPTH];
    int          fill [NTHR];
    logic [7:0]  pc [NTHR];
    logic [10:0] base [NTHR];
    logic [7:0]  mask;

    word_t expected_words[$];
    int    errors = 0;
    bit    quiet = 1'b0;

    function automatic logic [7:0] hrd(int t, logic [7:0] rel);
        return mem[11'(base[t] + 11'(rel))];
    endfunction

    function automatic void hwr(int t, logic [7:0] rel, logic [7:0] v);
        mem[11'(base[t] + 11'(rel))] = v;
    endfunction

    function automatic logic [7:0] fetch_operand(int t);
        logic [7:0] v;
        v = hrd(t, pc[t]);
        pc[t] = pc[t] + 8'd1;
        return v;
    endfunction

    function automatic void push_byte(int t, logic [7:0] v);
        if (fill[t] < SDEPTH)
        begin
            stk[t][fill[t]] = v;
            fill[t]++;
        end
    endfunction

    function automatic logic [7:0] pop_byte(int t);
        if (fill[t] == 0)
        begin
            return 8'd0;
        end
        fill[t]--;
        return stk[t][fill[t]];
    endfunction

    function automatic logic [7:0] step_thread(int t);
        logic [7:0] instr, oldpc, a, b, d;
        bit h1, h2;
        instr = hrd(t, pc[t]);
        oldpc = pc[t];
        h1 = fill[t] >= 1;
        h2 = fill[t] >= 2;
        pc[t] = oldpc + 8'd1;
        case (5'(instr % 24))
            OP_ORG:
            begin
                base[t] = base[t] + 11'(oldpc);
                pc[t] = 8'd1;
            end
            OP_EQU:
            begin
                if (h2)
                begin
                    a = pop_byte(t);
                    b = pop_byte(t);
                    push_byte(t, 8'(a == b));
                end
            end
            OP_JMP: pc[t] = hrd(t, pc[t]);
            OP_JMPZ:
            begin
                if (h1 && pop_byte(t) == 8'd0)
                    pc[t] = hrd(t, pc[t]);
                else
                    pc[t] = pc[t] + 8'd1;
            end
            OP_PSHL: push_byte(t, fetch_operand(t));
            OP_PSH:  push_byte(t, hrd(t, fetch_operand(t)));
            OP_PSHI: push_byte(t, hrd(t, hrd(t, fetch_operand(t))));
            OP_POP:
            begin
                if (h1)
                begin
                    d = fetch_operand(t);
                    hwr(t, d, pop_byte(t));
                end
            end
            OP_POPI:
            begin
                if (h1)
                begin
                    d = hrd(t, fetch_operand(t));
                    hwr(t, d, pop_byte(t));
                end
            end
            OP_ADD:
            begin
                if (h2)
                begin
                    a = pop_byte(t);
                    b = pop_byte(t);
                    push_byte(t, a + b);
                end
            end
            OP_SUB:
            begin
                if (h2)
                begin
                    a = pop_byte(t);
                    b = pop_byte(t);
                    push_byte(t, a - b);
                end
            end
            OP_INC: if (h1) push_byte(t, pop_byte(t) + 8'd1);
            OP_DEC: if (h1) push_byte(t, pop_byte(t) - 8'd1);
            OP_AND:
            begin
                if (h2)
                begin
                    a = pop_byte(t);
                    b = pop_byte(t);
                    push_byte(t, a & b);
                end
            end
            OP_OR:
            begin
                if (h2)
                begin
                    a = pop_byte(t);
                    b = pop_byte(t);
                    push_byte(t, a | b);
                end
            end
            OP_XOR:
            begin
                if (h2)
                begin
                    a = pop_byte(t);
                    b = pop_byte(t);
                    push_byte(t, a ^ b);
                end
            end
            OP_NOT: if (h1) push_byte(t, ~pop_byte(t));
            OP_ROR:
            begin
                if (h2)
                begin
                    a = pop_byte(t);
                    b = fetch_operand(t);
                    push_byte(t, a >> b[2:0]);
                end
            end
            OP_ROL:
            begin
                if (h2)
                begin
                    a = pop_byte(t);
                    b = fetch_operand(t);
                    push_byte(t, a << b[2:0]);
                end
            end
            OP_PIP:
            begin
                d = fetch_operand(t);
                hwr(t, d, hrd(t, d) + 8'd1);
            end
            OP_PDP:
            begin
                d = fetch_operand(t);
                hwr(t, d, hrd(t, d) - 8'd1);
            end
            OP_DUP: if (h1) push_byte(t, stk[t][fill[t] - 1]);
            default: ;
        endcase
        return instr;
    endfunction

    function automatic void predict_command(logic [1:0] op, logic [10:0] adr, logic [7:0] dat);
        word_t w;
        int n;
        n = 0;
        if (op == CMD_WRITE)
        begin
            mem[adr] = dat;
        end
        else if (op == CMD_READ)
        begin
            w.thr = 3'd0;
            w.val = mem[adr];
            w.lst = 1'b1;
            expected_words.push_back(w);
        end
        else if (op == CMD_TICK)
        begin
            for (int t = 0; t < NTHR; t++)
            begin
                if (mask[t])
                begin
                    w.thr = 3'(t);
                    w.val = step_thread(t);
                    w.lst = 1'b0;
                    expected_words.push_back(w);
                    n++;
                end
            end
            if (n > 0)
            begin
                expected_words[$].lst = 1'b1;
            end
        end
    endfunction

    // checker
    always @(posedge clk)
    begin
        word_t e;
        if (rst_n && strobe)
        begin
            if (expected_words.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word thr=%0d val=%0h last=%0b",
                        thread_index, value, last);
            end
            else
            begin
                e = expected_words.pop_front();
                if (e.thr !== thread_index || e.val !== value || e.lst !== last)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp thr=%0d val=%0h last=%0b got %0d %0h %0b",
                            e.thr, e.val, e.lst, thread_index, value, last);
                end
            end
        end
    end

    // start drops for a random gap; back to back commands keep it high
    task automatic idle_burst();
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic send_command(logic [1:0] op, logic [10:0] adr, logic [7:0] dat);
        idle_burst();
        start <= 1'b1;
        opcode <= op;
        address <= adr;
        data <= dat;
        do @(posedge clk); while (busy);
        predict_command(op, adr, dat);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic set_mask(logic [7:0] m);
        settle();
        cfg_write <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
        mask = m;
    endtask

    // write a small program at thread t's current pc
    task automatic load_program(int t, int len, bit wellformed);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = wellformed ? 8'($urandom_range(0, 23) + 24 * $urandom_range(0, 9))
                           : 8'($urandom);
            send_command(CMD_WRITE, 11'(base[t] + 11'(pc[t]) + 11'(i)), b);
        end
    endtask

    task automatic test_heap_access();
        send_command(CMD_WRITE, 11'd0, 8'hFF);
        send_command(CMD_WRITE, 11'd2047, 8'h00);
        send_command(CMD_WRITE, 11'd1365, 8'hAA);
        send_command(CMD_WRITE, 11'd682, 8'h55);
        send_command(CMD_READ, 11'd0, 8'd0);
        send_command(CMD_READ, 11'd2047, 8'd0);
        send_command(CMD_READ, 11'd1365, 8'd0);
        send_command(CMD_READ, 11'd682, 8'd0);
        send_command(CMD_UNUSED, 11'h7FF, 8'hFF);
        send_command(CMD_WRITE, 11'd0, 8'd0);
    endtask

    task automatic test_opcodes();
        // heap bytes 0 to 23 hold each opcode in turn (byte 3 PSHL, not JMP); operands are the bytes that follow
        for (int i = 0; i < 24; i++)
            send_command(CMD_WRITE, 11'(i), 8'(i == 3 ? 5 : (i + 24 * (i % 3))));
        send_command(CMD_TICK, 11'd0, 8'd0);
        set_mask(8'h00);
        send_command(CMD_TICK, 11'd0, 8'd0);
        set_mask(8'hFF);
        repeat (12) send_command(CMD_TICK, 11'h7FF, 8'hFF);
    endtask

    task automatic test_random(int count, bit fill_stacks);
        int n, r;
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 9);
            if (r < 2)
            begin
                load_program($urandom_range(0, NTHR - 1), $urandom_range(1, 6), r == 0);
                n++;
            end
            else if (r < 4)
            begin
                send_command(CMD_READ, 11'($urandom), 8'($urandom));
                n++;
            end
            else if (r == 4)
            begin
                send_command(CMD_WRITE, 11'($urandom), 8'($urandom));
                n++;
            end
            else
            begin
                send_command(CMD_TICK, 11'($urandom), 8'($urandom));
                n++;
            end
            if (fill_stacks && n % 20 == 0)
            begin
                for (int k = 0; k < 18; k++)
                begin
                    // pushes toward full stacks (PSHL with random operand)
                    send_command(CMD_WRITE, 11'(base[0] + 11'(pc[0])), {3'd0, OP_PSHL});
                    send_command(CMD_WRITE, 11'(base[0] + 11'(pc[0]) + 11'd1),
                        8'($urandom));
                    send_command(CMD_TICK, 11'd0, 8'd0);
                end
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < HBYTES; i++) mem[i] = 8'd0;
        for (int t = 0; t < NTHR; t++)
        begin
            fill[t] = 0;
            pc[t] = 8'd0;
            base[t] = 11'((255 * t) % HBYTES);
            for (int j = 0; j < SDEPTH; j++) stk[t][j] = 8'd0;
        end
        mask = 8'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_heap_access();
        test_opcodes();
        set_mask(8'h01);
        test_random(20, 1'b1);
        set_mask(8'($urandom));
        test_random(90, 1'b0);
        set_mask(8'hFF);
        test_random(70, 1'b0);
        set_mask(8'h80);
        quiet = 1'b1;
        test_random(60, 1'b0);
        settle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
